[design/seed_key_security_gate_assert.svh]
// ----------------------------------------------------------------------------
// seed_key_security_gate assertion macros
// Concurrent assertion wrappers clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef SEED_KEY_SECURITY_GATE_ASSERT_SVH
`define SEED_KEY_SECURITY_GATE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define SKG_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define SKG_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define SKG_ASSERT_IMP(label, ante, cons)
`define SKG_ASSERT_NXT(label, ante, cons)
`endif

`endif

[design/skg_pkg.sv]
// ----------------------------------------------------------------------------
// skg_pkg
// Shared types and constants of the seed/key security gate.
// ----------------------------------------------------------------------------
package skg_pkg;

    localparam int LINE_CAPACITY = 20;
    localparam int WP_W          = $clog2(LINE_CAPACITY + 1);
    localparam int IDX_W         = $clog2(LINE_CAPACITY);

    localparam int BYTE_W  = 8;
    localparam int SEED_W  = 27;
    localparam int CHAL_W  = 32;
    localparam int RESP_W  = 3;
    localparam int KEY_CHARS = 8;

    localparam logic [BYTE_W-1:0] BYTE_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] BYTE_BS = 8'h08;

    localparam logic [31:0] PAT_SEED    = "2701";
    localparam logic [31:0] PAT_KEY     = "2702";
    localparam logic [63:0] PAT_ROUTINE = "3101AA00";

    localparam logic [CHAL_W-1:0] KEY_RESET = 32'h0101_0101;
    localparam logic [SEED_W-1:0] SEED_MOD  = 27'd100000000;
    // floor(v / 10) == (v * RECIP10) >> RECIP_SHIFT for any 32-bit v
    localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;
    localparam int          QUOT_W      = SEED_W - 3;

    localparam logic [RESP_W-1:0] RESP_SEED        = 3'd0;
    localparam logic [RESP_W-1:0] RESP_ROUTINE_RUN = 3'd1;
    localparam logic [RESP_W-1:0] RESP_ROUTINE_REF = 3'd2;
    localparam logic [RESP_W-1:0] RESP_KEY_OK      = 3'd3;
    localparam logic [RESP_W-1:0] RESP_KEY_BAD     = 3'd4;

    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        CMD_SEED,
        CMD_ROUTINE,
        CMD_KEY
    } skg_cmd_t;

    typedef struct packed {
        skg_cmd_t                      cmd;
        logic                          short_line;
        logic [KEY_CHARS*BYTE_W-1:0]   key_chars;
        logic [SEED_W-1:0]             seed;
    } skg_entry_t;

    typedef struct packed {
        logic unlocked;
        logic pin;
    } skg_status_t;

endpackage

[design/skg_front.sv]
// ----------------------------------------------------------------------------
// skg_front
// Collects received bytes into a line and classifies the line on carriage
// return into a command entry for the execution side.
// ----------------------------------------------------------------------------
module skg_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 rx_byte,
    input  logic [26:0]                seed_value,
    input  logic                       q_full,
    output logic                       push,
    output skg_pkg::skg_entry_t        push_entry
);
    import skg_pkg::*;

    logic [BYTE_W-1:0] line_reg [LINE_CAPACITY];
    logic [WP_W-1:0]   wp_reg;
    logic [WP_W-1:0]   wp_next;
    logic              accept;
    logic [63:0]       head;
    logic [63:0]       key_chars;
    logic              hit_seed;
    logic              hit_routine;
    logic              hit_key;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign head      = {line_reg[0], line_reg[1], line_reg[2], line_reg[3],
                        line_reg[4], line_reg[5], line_reg[6], line_reg[7]};
    assign key_chars = {line_reg[4], line_reg[5], line_reg[6],  line_reg[7],
                        line_reg[8], line_reg[9], line_reg[10], line_reg[11]};

    assign hit_seed    = (wp_reg >= WP_W'(4)) && (head[63:32] == PAT_SEED);
    assign hit_routine = (wp_reg >= WP_W'(8)) && (head == PAT_ROUTINE);
    assign hit_key     = (wp_reg >= WP_W'(4)) && (head[63:32] == PAT_KEY);

    always_comb
    begin
        push_entry.key_chars  = key_chars;
        push_entry.seed       = seed_value;
        push_entry.short_line = (wp_reg < WP_W'(12));
        // first match wins: seed request, then routine, then key
        if (hit_seed)
        begin
            push_entry.cmd = CMD_SEED;
        end
        else if (hit_routine)
        begin
            push_entry.cmd = CMD_ROUTINE;
        end
        else
        begin
            push_entry.cmd = CMD_KEY;
        end
        push = accept && (rx_byte == BYTE_CR) && (hit_seed || hit_routine || hit_key);
    end

    always_comb
    begin
        wp_next = wp_reg;
        if (accept)
        begin
            if (rx_byte == BYTE_BS)
            begin
                if (wp_reg != '0)
                begin
                    wp_next = wp_reg - WP_W'(1);
                end
            end
            else if (rx_byte == BYTE_CR)
            begin
                wp_next = '0;
            end
            else if (wp_reg < WP_W'(LINE_CAPACITY))
            begin
                wp_next = wp_reg + WP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_next;
        end
    end

    // drop ordinary bytes once the line is full
    always_ff @(posedge clk)
    begin
        if (accept && rx_byte != BYTE_BS && rx_byte != BYTE_CR
            && wp_reg < WP_W'(LINE_CAPACITY))
        begin
            line_reg[wp_reg[IDX_W-1:0]] <= rx_byte;
        end
    end

endmodule

[design/skg_queue.sv]
// ----------------------------------------------------------------------------
// skg_queue
// Short command queue between line classification and execution.
// ----------------------------------------------------------------------------
module skg_queue
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  skg_pkg::skg_entry_t        push_entry,
    input  logic                       pop,
    output logic                       q_valid,
    output logic                       q_full,
    output skg_pkg::skg_entry_t        head_entry
);
    import skg_pkg::*;

    skg_entry_t          mem_reg [Q_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QPTR_W:0]     count_reg;
    logic [QPTR_W:0]     count_next;
    logic                do_push;
    logic                do_pop;

    assign q_valid    = (count_reg != '0);
    assign q_full     = (count_reg == (QPTR_W+1)'(Q_DEPTH));
    assign head_entry = mem_reg[rd_ptr_reg];

    assign do_push = push && !q_full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[design/skg_back.sv]
// ----------------------------------------------------------------------------
// skg_back
// Executes queued commands: seed-to-challenge conversion one decimal digit
// per cycle, key compare, routine gating, and the result output register.
// ----------------------------------------------------------------------------
module skg_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  skg_pkg::skg_entry_t        head_entry,
    output logic                       pop,
    input  logic [31:0]                key_value,
    output skg_pkg::skg_status_t       status,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [2:0]                 response,
    output logic [26:0]                seed_out,
    output logic [31:0]                challenge_digits,
    output logic                       unlock_pin
);
    import skg_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [2:0]          cnt_reg;
    logic [2:0]          cnt_next;
    logic [SEED_W-1:0]   val_reg;
    logic [SEED_W-1:0]   val_next;
    logic [CHAL_W-1:0]   bcd_reg;
    logic [CHAL_W-1:0]   bcd_next;
    logic [SEED_W-1:0]   seed_reg;
    logic [SEED_W-1:0]   seed_next;
    logic [CHAL_W-1:0]   chal_reg;
    logic [CHAL_W-1:0]   chal_next;
    logic                chal_valid_reg;
    logic                chal_valid_next;
    logic                unlocked_reg;
    logic                unlocked_next;
    logic                pin_reg;
    logic                pin_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [RESP_W-1:0]   resp_reg;
    logic [RESP_W-1:0]   resp_next;
    logic [SEED_W-1:0]   sout_reg;
    logic [SEED_W-1:0]   sout_next;
    logic [CHAL_W-1:0]   cout_reg;
    logic [CHAL_W-1:0]   cout_next;
    logic                pin_out_reg;
    logic                pin_out_next;

    logic                out_free;
    logic                load_out;
    logic [SEED_W+31:0]  prod;
    logic [QUOT_W-1:0]   quot;
    logic [SEED_W-1:0]   quot_x10;
    logic [3:0]          digit;
    logic [SEED_W-1:0]   seed_red;
    logic [KEY_CHARS-1:0] char_ok;
    logic                key_bad;

    assign out_free = !out_valid_reg || out_ready;

    // one divide-by-ten step through the reciprocal
    assign prod     = SEED_W'(val_reg) * RECIP10;
    assign quot     = prod[RECIP_SHIFT +: QUOT_W];
    assign quot_x10 = (SEED_W'(quot) << 3) + (SEED_W'(quot) << 1);
    assign digit    = 4'(val_reg - quot_x10);

    // keep the eight low decimal digits; seed stays below twice the modulus
    assign seed_red = (head_entry.seed >= SEED_MOD) ? head_entry.seed - SEED_MOD
                                                    : head_entry.seed;

    always_comb
    begin
        for (int k = 0; k < KEY_CHARS; k++)
        begin
            char_ok[k] = head_entry.key_chars[(KEY_CHARS-1-k)*BYTE_W +: BYTE_W]
                         == {4'h3, chal_reg[(KEY_CHARS-1-k)*4 +: 4]};
        end
    end

    assign key_bad = !chal_valid_reg || head_entry.short_line || (char_ok != '1);

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        val_next        = val_reg;
        bcd_next        = bcd_reg;
        seed_next       = seed_reg;
        chal_next       = chal_reg;
        chal_valid_next = chal_valid_reg;
        unlocked_next   = unlocked_reg;
        pin_next        = pin_reg;
        resp_next       = resp_reg;
        sout_next       = sout_reg;
        cout_next       = cout_reg;
        pin_out_next    = pin_out_reg;
        pop             = 1'b0;
        load_out        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (head_entry.cmd)
                        CMD_SEED:
                        begin
                            pop        = 1'b1;
                            seed_next  = head_entry.seed;
                            val_next   = seed_red;
                            cnt_next   = '0;
                            state_next = ST_CONV;
                        end
                        CMD_ROUTINE:
                        begin
                            if (out_free)
                            begin
                                pop       = 1'b1;
                                load_out  = 1'b1;
                                sout_next = '0;
                                cout_next = '0;
                                if (unlocked_reg)
                                begin
                                    pin_next  = 1'b1;
                                    resp_next = RESP_ROUTINE_RUN;
                                end
                                else
                                begin
                                    resp_next = RESP_ROUTINE_REF;
                                end
                                pin_out_next = unlocked_reg || pin_reg;
                            end
                        end
                        default:
                        begin
                            if (out_free)
                            begin
                                pop          = 1'b1;
                                load_out     = 1'b1;
                                sout_next    = '0;
                                cout_next    = '0;
                                pin_out_next = pin_reg;
                                if (!key_bad)
                                begin
                                    unlocked_next = 1'b1;
                                    resp_next     = RESP_KEY_OK;
                                end
                                else
                                begin
                                    resp_next = RESP_KEY_BAD;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_CONV:
            begin
                // digits arrive least significant first; shift in from the top
                val_next = SEED_W'(quot);
                bcd_next = {digit, bcd_reg[CHAL_W-1:4]};
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    load_out        = 1'b1;
                    chal_next       = bcd_reg ^ key_value;
                    chal_valid_next = 1'b1;
                    resp_next       = RESP_SEED;
                    sout_next       = seed_reg;
                    cout_next       = bcd_reg ^ key_value;
                    pin_out_next    = pin_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            chal_reg       <= '0;
            chal_valid_reg <= 1'b0;
            unlocked_reg   <= 1'b0;
            pin_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            chal_reg       <= chal_next;
            chal_valid_reg <= chal_valid_next;
            unlocked_reg   <= unlocked_next;
            pin_reg        <= pin_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg     <= val_next;
        bcd_reg     <= bcd_next;
        seed_reg    <= seed_next;
        resp_reg    <= resp_next;
        sout_reg    <= sout_next;
        cout_reg    <= cout_next;
        pin_out_reg <= pin_out_next;
    end

    assign status.unlocked  = unlocked_reg;
    assign status.pin       = pin_reg;
    assign out_valid        = out_valid_reg;
    assign response         = resp_reg;
    assign seed_out         = sout_reg;
    assign challenge_digits = cout_reg;
    assign unlock_pin       = pin_out_reg;

endmodule

[design/seed_key_security_gate.sv]
// ----------------------------------------------------------------------------
// seed_key_security_gate
// Line-based seed/key unlock gate: line capture, command queue, execution.
// ----------------------------------------------------------------------------
// Throughput: one received byte per cycle while the two-entry command queue
//   has room; a seed request holds the execution side through digit conversion.
// Result path: the carriage return pushes an entry into the command queue;
//   the result register loads from the queue head once the output is free.
// Reset: rst_n clears line length, queue, lock state, pin and challenge, and
//   loads the key register with 0x01010101; no clearing pass is needed.
// ----------------------------------------------------------------------------
module seed_key_security_gate
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [7:0]   rx_byte,
    input  logic [26:0]  seed_value,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [2:0]   response,
    output logic [26:0]  seed_out,
    output logic [31:0]  challenge_digits,
    output logic         unlock_pin,
    input  logic         cfg_we,
    input  logic [31:0]  key_digits
);
    import skg_pkg::*;

`include "seed_key_security_gate_assert.svh"

    logic [CHAL_W-1:0] key_reg;
    logic [CHAL_W-1:0] key_next;
    logic              q_full;
    logic              q_valid;
    logic              push;
    logic              pop;
    skg_entry_t        push_entry;
    skg_entry_t        head_entry;
    skg_status_t       status;

    assign key_next = cfg_we ? key_digits : key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= KEY_RESET;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

    skg_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .seed_value (seed_value),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    skg_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_full     (q_full),
        .head_entry (head_entry)
    );

    skg_back u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .head_entry       (head_entry),
        .pop              (pop),
        .key_value        (key_reg),
        .status           (status),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .response         (response),
        .seed_out         (seed_out),
        .challenge_digits (challenge_digits),
        .unlock_pin       (unlock_pin)
    );

    `SKG_ASSERT_NXT(a_pin_sticky, status.pin, status.pin)
    `SKG_ASSERT_IMP(a_pin_needs_unlock, status.pin, status.unlocked)
    `SKG_ASSERT_IMP(a_zero_fields, out_valid && response != RESP_SEED, seed_out == '0 && challenge_digits == '0)
    `SKG_ASSERT_IMP(a_run_drives_pin, out_valid && response == RESP_ROUTINE_RUN, unlock_pin)

endmodule
